// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the graphics register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition holds in every cycle out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`endif

// File: sv/gcr_pkg.sv
// ----------------------------------------------------------------------------
// Graphics control register package
// Request codes, register addresses, interrupt numbers and the decode struct.
// ----------------------------------------------------------------------------
package gcr_pkg;

	localparam int FILL_MAX = 2;
	localparam int SCR_MAX  = 2;

	// Request codes.
	localparam logic [2:0] MODE_READ      = 3'd0;
	localparam logic [2:0] MODE_WRITE     = 3'd1;
	localparam logic [2:0] MODE_FILL_DONE = 3'd2;
	localparam logic [2:0] MODE_XFER_DONE = 3'd3;
	localparam logic [2:0] MODE_LIST_DONE = 3'd4;

	// Word selection inside a fill unit.
	localparam logic [1:0] FILL_REG_BEGIN   = 2'd0;
	localparam logic [1:0] FILL_REG_END     = 2'd1;
	localparam logic [1:0] FILL_REG_PATTERN = 2'd2;
	localparam logic [1:0] FILL_REG_CTRL    = 2'd3;

	// Screen descriptor offsets.
	localparam logic [7:0] SCR_LEFT_A  = 8'h68;
	localparam logic [7:0] SCR_LEFT_B  = 8'h6C;
	localparam logic [7:0] SCR_FORMAT  = 8'h70;
	localparam logic [7:0] SCR_SELECT  = 8'h78;
	localparam logic [7:0] SCR_RIGHT_A = 8'h94;
	localparam logic [7:0] SCR_RIGHT_B = 8'h98;

	// Transfer and command-list addresses.
	localparam logic [12:0] ADDR_XFER_SRC    = 13'h0C00;
	localparam logic [12:0] ADDR_XFER_DST    = 13'h0C04;
	localparam logic [12:0] ADDR_XFER_FLAGS  = 13'h0C10;
	localparam logic [12:0] ADDR_XFER_CTRL   = 13'h0C18;
	localparam logic [12:0] ADDR_XFER_LEN    = 13'h0C20;
	localparam logic [12:0] ADDR_XFER_IN     = 13'h0C24;
	localparam logic [12:0] ADDR_XFER_OUT    = 13'h0C28;
	localparam logic [12:0] ADDR_LIST_COUNT  = 13'h18E0;
	localparam logic [12:0] ADDR_LIST_ADDR   = 13'h18E8;
	localparam logic [12:0] ADDR_LIST_CTRL   = 13'h18F0;

	// Interrupt numbers.
	localparam logic [5:0] IRQ_FILL_BASE = 6'd40;
	localparam logic [5:0] IRQ_TRANSFER  = 6'd44;

	// Decoded strobes for one request.
	typedef struct packed {
		logic [FILL_MAX-1:0] fill_wr_begin;
		logic [FILL_MAX-1:0] fill_wr_end;
		logic [FILL_MAX-1:0] fill_wr_pattern;
		logic [FILL_MAX-1:0] fill_wr_ctrl;
		logic [FILL_MAX-1:0] fill_rd_status;
		logic [FILL_MAX-1:0] fill_done;
		logic [SCR_MAX-1:0]  scr_wr_left_a;
		logic [SCR_MAX-1:0]  scr_wr_left_b;
		logic [SCR_MAX-1:0]  scr_wr_right_a;
		logic [SCR_MAX-1:0]  scr_wr_right_b;
		logic [SCR_MAX-1:0]  scr_wr_format;
		logic [SCR_MAX-1:0]  scr_wr_select;
		logic [SCR_MAX-1:0]  scr_rd_left_a;
		logic [SCR_MAX-1:0]  scr_rd_left_b;
		logic [SCR_MAX-1:0]  scr_rd_right_a;
		logic [SCR_MAX-1:0]  scr_rd_right_b;
		logic [SCR_MAX-1:0]  scr_rd_select;
		logic                xfer_wr_src;
		logic                xfer_wr_dst;
		logic                xfer_wr_flags;
		logic                xfer_wr_ctrl;
		logic                xfer_wr_len;
		logic                xfer_wr_in;
		logic                xfer_wr_out;
		logic                xfer_rd_status;
		logic                xfer_done;
		logic                list_wr_count;
		logic                list_wr_addr;
		logic                list_wr_ctrl;
		logic                list_rd_status;
		logic                list_done;
	} gcr_dec_t;

endpackage

// File: sv/gcr_decode.sv
// ----------------------------------------------------------------------------
// Graphics control register address decoder
// Turns one registered request into one-hot read and write strobes.
// ----------------------------------------------------------------------------
module gcr_decode
	import gcr_pkg::*;
#(
	parameter int FILL_UNITS = 2,
	parameter int SCREENS    = 2
) (
	input  logic        valid,
	input  logic [2:0]  mode,
	input  logic [12:0] address,
	input  logic        unit_index,
	output gcr_dec_t    dec
);

	logic is_rd;
	logic is_wr;
	logic fill_hit;
	logic scr_hit;

	assign is_rd    = valid && (mode == MODE_READ);
	assign is_wr    = valid && (mode == MODE_WRITE);
	// Fill units sit at 0x10 to 0x2F, sixteen bytes each.
	assign fill_hit = (address[12:6] == 7'd0) && (address[5] != address[4]);
	// Screen descriptors sit at 0x400 to 0x5FF, one page each.
	assign scr_hit  = (address[12:9] == 4'b0010);

	// Strobe generation.
	always_comb begin
		dec = '0;
		for (int u = 0; u < FILL_MAX; u++) begin
			if (u < FILL_UNITS && fill_hit && address[5] == u[0]) begin
				case (address[3:2])
					FILL_REG_BEGIN:   dec.fill_wr_begin[u]   = is_wr;
					FILL_REG_END:     dec.fill_wr_end[u]     = is_wr;
					FILL_REG_PATTERN: dec.fill_wr_pattern[u] = is_wr;
					FILL_REG_CTRL: begin
						dec.fill_wr_ctrl[u]   = is_wr;
						dec.fill_rd_status[u] = is_rd;
					end
					default: ;
				endcase
			end
			if (u < FILL_UNITS && unit_index == u[0])
				dec.fill_done[u] = valid && (mode == MODE_FILL_DONE);
		end
		for (int s = 0; s < SCR_MAX; s++) begin
			if (s < SCREENS && scr_hit && address[8] == s[0]) begin
				case (address[7:0])
					SCR_LEFT_A: begin
						dec.scr_wr_left_a[s] = is_wr;
						dec.scr_rd_left_a[s] = is_rd;
					end
					SCR_LEFT_B: begin
						dec.scr_wr_left_b[s] = is_wr;
						dec.scr_rd_left_b[s] = is_rd;
					end
					SCR_FORMAT: dec.scr_wr_format[s] = is_wr;
					SCR_SELECT: begin
						dec.scr_wr_select[s] = is_wr;
						dec.scr_rd_select[s] = is_rd;
					end
					SCR_RIGHT_A: begin
						dec.scr_wr_right_a[s] = is_wr;
						dec.scr_rd_right_a[s] = is_rd;
					end
					SCR_RIGHT_B: begin
						dec.scr_wr_right_b[s] = is_wr;
						dec.scr_rd_right_b[s] = is_rd;
					end
					default: ;
				endcase
			end
		end
		if (!fill_hit && !scr_hit) begin
			case (address)
				ADDR_XFER_SRC:   dec.xfer_wr_src   = is_wr;
				ADDR_XFER_DST:   dec.xfer_wr_dst   = is_wr;
				ADDR_XFER_FLAGS: dec.xfer_wr_flags = is_wr;
				ADDR_XFER_CTRL: begin
					dec.xfer_wr_ctrl   = is_wr;
					dec.xfer_rd_status = is_rd;
				end
				ADDR_XFER_LEN:   dec.xfer_wr_len   = is_wr;
				ADDR_XFER_IN:    dec.xfer_wr_in    = is_wr;
				ADDR_XFER_OUT:   dec.xfer_wr_out   = is_wr;
				ADDR_LIST_COUNT: dec.list_wr_count = is_wr;
				ADDR_LIST_ADDR:  dec.list_wr_addr  = is_wr;
				ADDR_LIST_CTRL: begin
					dec.list_wr_ctrl   = is_wr;
					dec.list_rd_status = is_rd;
				end
				default: ;
			endcase
		end
		dec.xfer_done = valid && (mode == MODE_XFER_DONE);
		dec.list_done = valid && (mode == MODE_LIST_DONE);
	end

endmodule

// File: sv/graphics_control_register_block.sv
// ----------------------------------------------------------------------------
// Graphics control register block: one request per cycle, busy stays low.
// Requests pass through the request register, then the result register with done.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Asynchronous active-low reset clears the register state and status bits, not the request payload.
// ----------------------------------------------------------------------------
module graphics_control_register_block
	import gcr_pkg::*;
#(
	parameter int FILL_UNITS = 2,
	parameter int SCREENS    = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [12:0] address,
	input  logic [31:0] write_data,
	input  logic        unit_index,
	output logic        done,
	output logic [31:0] read_data,
	output logic        fill_start,
	output logic        fill_start_index,
	output logic        transfer_start,
	output logic        command_start,
	output logic        irq_valid,
	output logic [5:0]  irq_line
);

	`include "assert_macros.svh"

	// Request register.
	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [12:0] address_s1;
	logic [31:0] data_s1;
	logic        unit_s1;

	// Register state.
	logic [31:0] scr_left_a_q  [SCREENS];
	logic [31:0] scr_left_b_q  [SCREENS];
	logic [31:0] scr_right_a_q [SCREENS];
	logic [31:0] scr_right_b_q [SCREENS];
	logic [2:0]  scr_format_q  [SCREENS];
	logic        scr_select_q  [SCREENS];
	logic [31:0] fill_begin_q   [FILL_UNITS];
	logic [31:0] fill_end_q     [FILL_UNITS];
	logic [31:0] fill_pattern_q [FILL_UNITS];
	logic [1:0]  fill_size_q    [FILL_UNITS];
	logic        fill_busy_q    [FILL_UNITS];
	logic        fill_finished_q[FILL_UNITS];
	logic [31:0] xfer_src_q;
	logic [31:0] xfer_dst_q;
	logic [31:0] xfer_flags_q;
	logic [31:0] xfer_len_q;
	logic [19:0] xfer_in_width_q;
	logic [19:0] xfer_in_gap_q;
	logic [19:0] xfer_out_width_q;
	logic [19:0] xfer_out_gap_q;
	logic        xfer_busy_q;
	logic        xfer_finished_q;
	logic [31:0] list_count_q;
	logic [31:0] list_addr_q;
	logic        list_busy_q;

	// Result register.
	logic        done_q;
	logic [31:0] read_data_q;
	logic        fill_start_q;
	logic        fill_start_index_q;
	logic        transfer_start_q;
	logic        command_start_q;
	logic        irq_valid_q;
	logic [5:0]  irq_line_q;

	gcr_dec_t    dec;
	logic [31:0] rd_mux;
	logic        fill_go;
	logic        xfer_go;
	logic        list_go;
	logic        fill_irq;

	// The block never stalls a request.
	assign busy = 1'b0;

	// Capture the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1    <= mode;
			address_s1 <= address;
			data_s1    <= write_data;
			unit_s1    <= unit_index;
		end
	end

	gcr_decode #(
		.FILL_UNITS (FILL_UNITS),
		.SCREENS    (SCREENS)
	) u_decode (
		.valid      (valid_s1),
		.mode       (mode_s1),
		.address    (address_s1),
		.unit_index (unit_s1),
		.dec        (dec)
	);

	// Start pulses and interrupt sources.
	assign fill_go  = (|dec.fill_wr_ctrl) && data_s1[0];
	assign xfer_go  = dec.xfer_wr_ctrl && data_s1[0];
	assign list_go  = dec.list_wr_ctrl && data_s1[0];
	assign fill_irq = |dec.fill_done;

	// Read data: the read strobes are one-hot, so the sources are ORed.
	always_comb begin
		rd_mux = '0;
		for (int u = 0; u < FILL_UNITS; u++) begin
			if (dec.fill_rd_status[u])
				rd_mux = rd_mux | {30'd0, fill_finished_q[u], fill_busy_q[u]};
		end
		for (int s = 0; s < SCREENS; s++) begin
			if (dec.scr_rd_left_a[s])  rd_mux = rd_mux | scr_left_a_q[s];
			if (dec.scr_rd_left_b[s])  rd_mux = rd_mux | scr_left_b_q[s];
			if (dec.scr_rd_right_a[s]) rd_mux = rd_mux | scr_right_a_q[s];
			if (dec.scr_rd_right_b[s]) rd_mux = rd_mux | scr_right_b_q[s];
			if (dec.scr_rd_select[s])  rd_mux = rd_mux | {31'd0, scr_select_q[s]};
		end
		if (dec.xfer_rd_status)
			rd_mux = rd_mux | {23'd0, xfer_finished_q, 7'd0, xfer_busy_q};
		if (dec.list_rd_status)
			rd_mux = rd_mux | {31'd0, list_busy_q};
	end

	// Screen descriptors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SCREENS; s++) begin
				scr_left_a_q[s]  <= '0;
				scr_left_b_q[s]  <= '0;
				scr_right_a_q[s] <= '0;
				scr_right_b_q[s] <= '0;
				scr_format_q[s]  <= '0;
				scr_select_q[s]  <= 1'b0;
			end
		end else begin
			for (int s = 0; s < SCREENS; s++) begin
				if (dec.scr_wr_left_a[s])  scr_left_a_q[s]  <= data_s1;
				if (dec.scr_wr_left_b[s])  scr_left_b_q[s]  <= data_s1;
				if (dec.scr_wr_right_a[s]) scr_right_a_q[s] <= data_s1;
				if (dec.scr_wr_right_b[s]) scr_right_b_q[s] <= data_s1;
				if (dec.scr_wr_format[s])  scr_format_q[s]  <= data_s1[2:0];
				if (dec.scr_wr_select[s])  scr_select_q[s]  <= data_s1[0];
			end
		end
	end

	// Fill units: settings, busy and finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < FILL_UNITS; u++) begin
				fill_begin_q[u]    <= '0;
				fill_end_q[u]      <= '0;
				fill_pattern_q[u]  <= '0;
				fill_size_q[u]     <= '0;
				fill_busy_q[u]     <= 1'b0;
				fill_finished_q[u] <= 1'b0;
			end
		end else begin
			for (int u = 0; u < FILL_UNITS; u++) begin
				if (dec.fill_wr_begin[u])   fill_begin_q[u]   <= {data_s1[28:0], 3'd0};
				if (dec.fill_wr_end[u])     fill_end_q[u]     <= {data_s1[28:0], 3'd0};
				if (dec.fill_wr_pattern[u]) fill_pattern_q[u] <= data_s1;
				if (dec.fill_wr_ctrl[u]) begin
					fill_finished_q[u] <= 1'b0;
					fill_size_q[u]     <= data_s1[9:8];
					if (data_s1[0])
						fill_busy_q[u] <= 1'b1;
				end
				if (dec.fill_done[u]) begin
					fill_busy_q[u]     <= 1'b0;
					fill_finished_q[u] <= 1'b1;
				end
			end
		end
	end

	// Transfer DMA and command-list settings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_src_q       <= '0;
			xfer_dst_q       <= '0;
			xfer_flags_q     <= '0;
			xfer_len_q       <= '0;
			xfer_in_width_q  <= '0;
			xfer_in_gap_q    <= '0;
			xfer_out_width_q <= '0;
			xfer_out_gap_q   <= '0;
			xfer_busy_q      <= 1'b0;
			xfer_finished_q  <= 1'b0;
			list_count_q     <= '0;
			list_addr_q      <= '0;
			list_busy_q      <= 1'b0;
		end else begin
			if (dec.xfer_wr_src)   xfer_src_q   <= {data_s1[28:0], 3'd0};
			if (dec.xfer_wr_dst)   xfer_dst_q   <= {data_s1[28:0], 3'd0};
			if (dec.xfer_wr_flags) xfer_flags_q <= data_s1;
			if (dec.xfer_wr_len)   xfer_len_q   <= data_s1;
			if (dec.xfer_wr_in) begin
				xfer_in_width_q <= {data_s1[15:0], 4'd0};
				xfer_in_gap_q   <= {data_s1[31:16], 4'd0};
			end
			if (dec.xfer_wr_out) begin
				xfer_out_width_q <= {data_s1[15:0], 4'd0};
				xfer_out_gap_q   <= {data_s1[31:16], 4'd0};
			end
			if (xfer_go) begin
				xfer_busy_q     <= 1'b1;
				xfer_finished_q <= 1'b0;
			end
			if (dec.xfer_done) begin
				xfer_busy_q     <= 1'b0;
				xfer_finished_q <= 1'b1;
			end
			if (dec.list_wr_count) list_count_q <= {data_s1[30:0], 1'b0};
			if (dec.list_wr_addr)  list_addr_q  <= {data_s1[28:0], 3'd0};
			if (list_go)           list_busy_q  <= 1'b1;
			if (dec.list_done)     list_busy_q  <= 1'b0;
		end
	end

	// Result register: one strobed result per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q             <= 1'b0;
			read_data_q        <= '0;
			fill_start_q       <= 1'b0;
			fill_start_index_q <= 1'b0;
			transfer_start_q   <= 1'b0;
			command_start_q    <= 1'b0;
			irq_valid_q        <= 1'b0;
			irq_line_q         <= '0;
		end else begin
			done_q             <= valid_s1;
			read_data_q        <= rd_mux;
			fill_start_q       <= fill_go;
			fill_start_index_q <= fill_go && dec.fill_wr_ctrl[FILL_MAX-1];
			transfer_start_q   <= xfer_go;
			command_start_q    <= list_go;
			irq_valid_q        <= fill_irq || dec.xfer_done;
			if (dec.xfer_done)
				irq_line_q <= IRQ_TRANSFER;
			else if (fill_irq)
				irq_line_q <= IRQ_FILL_BASE + {5'd0, dec.fill_done[FILL_MAX-1]};
			else
				irq_line_q <= '0;
		end
	end

	assign done             = done_q;
	assign read_data        = read_data_q;
	assign fill_start       = fill_start_q;
	assign fill_start_index = fill_start_index_q;
	assign transfer_start   = transfer_start_q;
	assign command_start    = command_start_q;
	assign irq_valid        = irq_valid_q;
	assign irq_line         = irq_line_q;

	// A request causes at most one start pulse or interrupt.
	`ASSERT_ALWAYS(a_one_event, clk, arst_n,
		$onehot0({fill_start, transfer_start, command_start, irq_valid}))
	// Side effects only appear with the result strobe.
	`ASSERT_IMPLIES(a_event_done, clk, arst_n,
		fill_start || transfer_start || command_start || irq_valid || read_data != '0, done)
	// A transfer start leaves the transfer marked busy.
	`ASSERT_IMPLIES(a_xfer_busy, clk, arst_n, transfer_start, xfer_busy_q && !xfer_finished_q)
	// Interrupt numbers are confined to the fill and transfer lines.
	`ASSERT_IMPLIES(a_irq_line, clk, arst_n, irq_valid,
		irq_line == IRQ_TRANSFER || irq_line == IRQ_FILL_BASE || irq_line == IRQ_FILL_BASE + 6'd1)

endmodule

// File: tb/gcr_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graphics control register result checker
// Watches the request and result channels of the register block, keeps its
// own copy of every register and status bit, predicts the response to each
// accepted request and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module gcr_result_checker
	import gcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  mode,
	input  logic [12:0] address,
	input  logic [31:0] write_data,
	input  logic        unit_index,
	input  logic        done,
	input  logic [31:0] read_data,
	input  logic        fill_start,
	input  logic        fill_start_index,
	input  logic        transfer_start,
	input  logic        command_start,
	input  logic        irq_valid,
	input  logic [5:0]  irq_line,
	output int          fail_count,
	output int          pending
);

	localparam logic [12:0] FILL_LO   = 13'h010;
	localparam logic [12:0] FILL_HI   = 13'h030;
	localparam logic [12:0] SCR_LO    = 13'h400;
	localparam logic [12:0] SCR_HI    = 13'h600;
	localparam int          PRINT_MAX = 200;

	typedef struct packed {
		logic [31:0] read_data;
		logic        fill_start;
		logic        fill_start_index;
		logic        transfer_start;
		logic        command_start;
		logic        irq_valid;
		logic [5:0]  irq_line;
	} gcr_response_t;

	// Shadow copy of the register file.
	logic [31:0] scr_left_a  [SCR_MAX];
	logic [31:0] scr_left_b  [SCR_MAX];
	logic [31:0] scr_right_a [SCR_MAX];
	logic [31:0] scr_right_b [SCR_MAX];
	logic [2:0]  scr_format  [SCR_MAX];
	logic        scr_select  [SCR_MAX];
	logic [31:0] fill_begin    [FILL_MAX];
	logic [31:0] fill_end      [FILL_MAX];
	logic [31:0] fill_pattern  [FILL_MAX];
	logic [1:0]  fill_size     [FILL_MAX];
	logic        fill_busy     [FILL_MAX];
	logic        fill_finished [FILL_MAX];
	logic [31:0] xfer_src, xfer_dst, xfer_flags, xfer_len;
	logic [19:0] xfer_in_width, xfer_in_gap, xfer_out_width, xfer_out_gap;
	logic        xfer_busy, xfer_finished;
	logic [31:0] list_count, list_addr;
	logic        list_busy;

	gcr_response_t predicted_responses [$];
	gcr_response_t oldest;

	// Return the shadow registers to their reset values.
	task automatic clear_registers();
		for (int i = 0; i < SCR_MAX; i++) begin
			scr_left_a[i]  = '0;
			scr_left_b[i]  = '0;
			scr_right_a[i] = '0;
			scr_right_b[i] = '0;
			scr_format[i]  = '0;
			scr_select[i]  = 1'b0;
		end
		for (int i = 0; i < FILL_MAX; i++) begin
			fill_begin[i]    = '0;
			fill_end[i]      = '0;
			fill_pattern[i]  = '0;
			fill_size[i]     = '0;
			fill_busy[i]     = 1'b0;
			fill_finished[i] = 1'b0;
		end
		{xfer_src, xfer_dst, xfer_flags, xfer_len} = '0;
		{xfer_in_width, xfer_in_gap, xfer_out_width, xfer_out_gap} = '0;
		{xfer_busy, xfer_finished} = '0;
		{list_count, list_addr, list_busy} = '0;
	endtask

	function automatic logic unit_bit(input int u);
		return (u != 0);
	endfunction

	// Apply one request to the shadow registers and return the response it gives.
	function automatic gcr_response_t apply_request(input logic [2:0] m, input logic [12:0] a,
			input logic [31:0] d, input logic unit);
		gcr_response_t r;
		logic          wr;
		int            u;
		int            s;
		logic [7:0]    off;
		r   = '0;
		wr  = (m == MODE_WRITE);
		off = a[7:0];
		if (m == MODE_READ || m == MODE_WRITE) begin
			if (a >= FILL_LO && a < FILL_HI) begin
				u = (int'(a) - int'(FILL_LO)) / 16;
				if (!wr) begin
					if (a[3:2] == FILL_REG_CTRL)
						r.read_data = {30'b0, fill_finished[u], fill_busy[u]};
				end else begin
					case (a[3:2])
						FILL_REG_BEGIN:   fill_begin[u]   = d << 3;
						FILL_REG_END:     fill_end[u]     = d << 3;
						FILL_REG_PATTERN: fill_pattern[u] = d;
						default: begin
							fill_finished[u] = 1'b0;
							fill_size[u]     = d[9:8];
							if (d[0]) begin
								fill_busy[u]       = 1'b1;
								r.fill_start       = 1'b1;
								r.fill_start_index = unit_bit(u);
							end
						end
					endcase
				end
			end else if (a >= SCR_LO && a < SCR_HI) begin
				s = int'(a >> 8) - int'(SCR_LO >> 8);
				if (wr) begin
					case (off)
						SCR_LEFT_A:  scr_left_a[s]  = d;
						SCR_LEFT_B:  scr_left_b[s]  = d;
						SCR_FORMAT:  scr_format[s]  = d[2:0];
						SCR_SELECT:  scr_select[s]  = d[0];
						SCR_RIGHT_A: scr_right_a[s] = d;
						SCR_RIGHT_B: scr_right_b[s] = d;
						default: ;
					endcase
				end else begin
					case (off)
						SCR_LEFT_A:  r.read_data = scr_left_a[s];
						SCR_LEFT_B:  r.read_data = scr_left_b[s];
						SCR_SELECT:  r.read_data = {31'b0, scr_select[s]};
						SCR_RIGHT_A: r.read_data = scr_right_a[s];
						SCR_RIGHT_B: r.read_data = scr_right_b[s];
						default: ;
					endcase
				end
			end else if (!wr) begin
				if (a == ADDR_XFER_CTRL)
					r.read_data = {23'b0, xfer_finished, 7'b0, xfer_busy};
				else if (a == ADDR_LIST_CTRL)
					r.read_data = {31'b0, list_busy};
			end else begin
				case (a)
					ADDR_XFER_SRC:   xfer_src   = d << 3;
					ADDR_XFER_DST:   xfer_dst   = d << 3;
					ADDR_XFER_FLAGS: xfer_flags = d;
					ADDR_XFER_CTRL: begin
						if (d[0]) begin
							xfer_busy        = 1'b1;
							xfer_finished    = 1'b0;
							r.transfer_start = 1'b1;
						end
					end
					ADDR_XFER_LEN: xfer_len = d;
					ADDR_XFER_IN: begin
						xfer_in_width = {d[15:0], 4'b0};
						xfer_in_gap   = {d[31:16], 4'b0};
					end
					ADDR_XFER_OUT: begin
						xfer_out_width = {d[15:0], 4'b0};
						xfer_out_gap   = {d[31:16], 4'b0};
					end
					ADDR_LIST_COUNT: list_count = d << 1;
					ADDR_LIST_ADDR:  list_addr  = d << 3;
					ADDR_LIST_CTRL: begin
						if (d[0]) begin
							list_busy       = 1'b1;
							r.command_start = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else if (m == MODE_FILL_DONE) begin
			// Completion is honoured even when the unit was idle.
			fill_busy[unit]     = 1'b0;
			fill_finished[unit] = 1'b1;
			r.irq_valid         = 1'b1;
			r.irq_line          = IRQ_FILL_BASE + {5'b0, unit};
		end else if (m == MODE_XFER_DONE) begin
			xfer_busy     = 1'b0;
			xfer_finished = 1'b1;
			r.irq_valid   = 1'b1;
			r.irq_line    = IRQ_TRANSFER;
		end else if (m == MODE_LIST_DONE) begin
			list_busy = 1'b0;
		end
		return r;
	endfunction

	// Print one mismatch line while fewer than PRINT_MAX are counted, and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < PRINT_MAX)
			$display("%0t checker: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Results are compared before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_registers();
			predicted_responses.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (predicted_responses.size() == 0) begin
					report_mismatch("result with no request outstanding", read_data, '0);
				end else begin
					oldest = predicted_responses.pop_front();
					if (read_data !== oldest.read_data)
						report_mismatch("read_data", read_data, oldest.read_data);
					if (fill_start !== oldest.fill_start)
						report_mismatch("fill_start", fill_start, oldest.fill_start);
					if (fill_start_index !== oldest.fill_start_index)
						report_mismatch("fill_start_index", fill_start_index,
							oldest.fill_start_index);
					if (transfer_start !== oldest.transfer_start)
						report_mismatch("transfer_start", transfer_start, oldest.transfer_start);
					if (command_start !== oldest.command_start)
						report_mismatch("command_start", command_start, oldest.command_start);
					if (irq_valid !== oldest.irq_valid)
						report_mismatch("irq_valid", irq_valid, oldest.irq_valid);
					if (irq_line !== oldest.irq_line)
						report_mismatch("irq_line", irq_line, oldest.irq_line);
				end
			end
			if (start && !busy)
				predicted_responses.push_back(apply_request(mode, address, write_data,
					unit_index));
			pending <= predicted_responses.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graphics control register block testbench
// Drives directed and random bus reads, writes and engine completion events
// with random gaps and bursts; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import gcr_pkg::*;

	localparam int          RANDOM_REQUESTS = 1100;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam int          GAP_MAX         = 17;
	localparam int          SETTLE_CYCLES   = 4;
	localparam logic [12:0] FILL_BASE       = 13'h010;
	localparam logic [12:0] SCR_BASE        = 13'h400;
	localparam logic [2:0]  MODE_RESERVED   = MODE_LIST_DONE + 3'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  mode = MODE_READ;
	logic [12:0] address = '0;
	logic [31:0] write_data = '0;
	logic        unit_index = 1'b0;
	logic        busy;
	logic        done;
	logic [31:0] read_data;
	logic        fill_start;
	logic        fill_start_index;
	logic        transfer_start;
	logic        command_start;
	logic        irq_valid;
	logic [5:0]  irq_line;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	logic        burst = 1'b0;

	logic [12:0] engine_regs [10] = '{ADDR_XFER_SRC, ADDR_XFER_DST, ADDR_XFER_FLAGS,
		ADDR_XFER_CTRL, ADDR_XFER_LEN, ADDR_XFER_IN, ADDR_XFER_OUT, ADDR_LIST_COUNT,
		ADDR_LIST_ADDR, ADDR_LIST_CTRL};
	logic [7:0]  scr_offsets [6] = '{SCR_LEFT_A, SCR_LEFT_B, SCR_FORMAT, SCR_SELECT,
		SCR_RIGHT_A, SCR_RIGHT_B};

	always #6 clk = ~clk;

	graphics_control_register_block u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.address          (address),
		.write_data       (write_data),
		.unit_index       (unit_index),
		.done             (done),
		.read_data        (read_data),
		.fill_start       (fill_start),
		.fill_start_index (fill_start_index),
		.transfer_start   (transfer_start),
		.command_start    (command_start),
		.irq_valid        (irq_valid),
		.irq_line         (irq_line)
	);

	gcr_result_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.address          (address),
		.write_data       (write_data),
		.unit_index       (unit_index),
		.done             (done),
		.read_data        (read_data),
		.fill_start       (fill_start),
		.fill_start_index (fill_start_index),
		.transfer_start   (transfer_start),
		.command_start    (command_start),
		.irq_valid        (irq_valid),
		.irq_line         (irq_line),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	function automatic logic [12:0] fill_addr(input int u, input logic [1:0] sel);
		return FILL_BASE + 13'(16 * u) + {9'b0, sel, 2'b0};
	endfunction

	function automatic logic [12:0] scr_addr(input int s, input logic [7:0] off);
		return SCR_BASE + 13'(256 * s) + {5'b0, off};
	endfunction

	// Mostly mapped registers, some near misses and some anywhere in the space.
	function automatic logic [12:0] random_address();
		logic [12:0] a;
		case ($urandom_range(0, 9))
			0, 1, 2: a = fill_addr($urandom_range(0, FILL_MAX - 1), 2'($urandom_range(0, 3)));
			3, 4:    a = scr_addr($urandom_range(0, SCR_MAX - 1),
				scr_offsets[$urandom_range(0, 5)]);
			5, 6:    a = engine_regs[$urandom_range(0, 9)];
			7:       a = engine_regs[$urandom_range(0, 9)] + 13'($urandom_range(1, 3));
			default: a = 13'($urandom_range(0, 8191));
		endcase
		return a;
	endfunction

	function automatic logic [31:0] random_data();
		logic [31:0] d;
		case ($urandom_range(0, 7))
			0:       d = '0;
			1:       d = '1;
			2:       d = 32'($urandom_range(0, 255));
			default: d = $urandom;
		endcase
		return d;
	endfunction

	// Present one request after a random gap, none in a burst, and hold it until it is accepted.
	task automatic issue(input logic [2:0] m, input logic [12:0] a, input logic [31:0] d,
			input logic u);
		int gap;
		gap = burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		address    <= a;
		write_data <= d;
		unit_index <= u;
		do @(posedge clk); while (busy);
	endtask

	// Hold off new requests until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [2:0] m;
		int         sel;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: status after reset, screen registers at the data extremes.
		issue(MODE_READ, fill_addr(1, FILL_REG_CTRL), '0, 1'b0);
		issue(MODE_READ, ADDR_XFER_CTRL, '0, 1'b1);
		issue(MODE_WRITE, scr_addr(0, SCR_LEFT_A), '1, 1'b0);
		issue(MODE_READ, scr_addr(0, SCR_LEFT_A), '0, 1'b0);
		issue(MODE_WRITE, scr_addr(1, SCR_RIGHT_B), 32'h8000_0001, 1'b1);
		issue(MODE_READ, scr_addr(1, SCR_RIGHT_B), '1, 1'b1);
		issue(MODE_WRITE, scr_addr(1, SCR_SELECT), '1, 1'b0);
		issue(MODE_READ, scr_addr(1, SCR_SELECT), '0, 1'b0);
		issue(MODE_WRITE, scr_addr(0, SCR_FORMAT), '1, 1'b0);
		issue(MODE_READ, scr_addr(0, SCR_FORMAT), '0, 1'b0);
		// Fill unit start, completion, and completion while idle.
		issue(MODE_WRITE, fill_addr(0, FILL_REG_BEGIN), '1, 1'b0);
		issue(MODE_WRITE, fill_addr(0, FILL_REG_CTRL), 32'h0000_0301, 1'b0);
		issue(MODE_READ, fill_addr(0, FILL_REG_CTRL), '0, 1'b0);
		issue(MODE_FILL_DONE, '1, '1, 1'b0);
		issue(MODE_READ, fill_addr(0, FILL_REG_CTRL), '0, 1'b0);
		issue(MODE_FILL_DONE, '0, '0, 1'b1);
		// Start while busy pulses again.
		issue(MODE_WRITE, fill_addr(1, FILL_REG_CTRL), 32'h0000_0001, 1'b0);
		issue(MODE_WRITE, fill_addr(1, FILL_REG_CTRL), '1, 1'b0);
		// Transfer and command list round trips.
		issue(MODE_WRITE, ADDR_XFER_CTRL, 32'h0000_0001, 1'b0);
		issue(MODE_XFER_DONE, '0, '0, 1'b0);
		issue(MODE_READ, ADDR_XFER_CTRL, '0, 1'b0);
		issue(MODE_WRITE, ADDR_LIST_CTRL, '1, 1'b0);
		issue(MODE_LIST_DONE, '0, '0, 1'b0);
		issue(MODE_READ, ADDR_LIST_CTRL, '0, 1'b0);
		// Unmapped and unaligned accesses, then the undefined request codes.
		issue(MODE_READ, '1, '0, 1'b0);
		issue(MODE_WRITE, scr_addr(0, SCR_LEFT_A + 8'd1), '1, 1'b0);
		issue(MODE_READ, scr_addr(0, SCR_LEFT_A + 8'd1), '0, 1'b0);
		for (int k = 0; k < 3; k++)
			issue(MODE_RESERVED + 3'(k), ADDR_XFER_CTRL, '1, 1'b1);
		drain();

		// Random: bursts or gapped stretches, chosen anew every 40 requests.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_REQUESTS / 2)
				drain();
			sel = $urandom_range(0, 99);
			if (sel < 38)      m = MODE_READ;
			else if (sel < 74) m = MODE_WRITE;
			else if (sel < 83) m = MODE_FILL_DONE;
			else if (sel < 89) m = MODE_XFER_DONE;
			else if (sel < 95) m = MODE_LIST_DONE;
			else               m = 3'($urandom_range(0, 7));
			issue(m, random_address(), random_data(), 1'($urandom_range(0, 1)));
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
